// File: rtl/dde_pkg.sv
// Shared widths and constants of the direct DFT engine.
`default_nettype none

package dde_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TW_W     = 16;
    localparam int PROD_W   = SAMPLE_W + TW_W;
    localparam int ACC_W    = 24;
    localparam int OUT_W    = 23;
    localparam int BIN_W    = 6;
    localparam int RECIP_W  = 30;
    localparam int DIV_SHIFT = 30;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam logic signed [ACC_W-1:0] SAT_HI = 24'sd4194303;
    localparam logic signed [ACC_W-1:0] SAT_LO = -24'sd4194304;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] imag;
        logic signed [SAMPLE_W-1:0] real_part;
    } sample_t;

    typedef struct packed {
        logic signed [TW_W-1:0] cos_v;
        logic signed [TW_W-1:0] sin_v;
    } twiddle_t;

endpackage

`default_nettype wire

// File: rtl/direct_dft_engine.sv
// Direct DFT engine: sample store, twiddle table, shared complex MAC and sequencer.
`default_nettype none

// A frame of POINTS complex Q15 samples is loaded one request per cycle while busy
// is low; the request that delivers the last sample starts the transform and raises
// busy. Each bin then runs all POINTS samples through the single shared complex
// multiply accumulate, fed by the sample store read port, followed by pipeline drain,
// scaling and output. Every bin is shown on the result ports for exactly one cycle
// with result_strobe high, in index order, with last_bin set on the final one; the
// receiver cannot stall, so results must be taken as they appear. The inverse setting
// sampled with the last sample selects the mode for the whole frame; write it only
// while busy is low.
module direct_dft_engine #(
    parameter int POINTS = 64
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write_en,
    input  wire                                cfg_write_data,
    input  wire                                start,
    output logic                               busy,
    input  wire  signed [dde_pkg::SAMPLE_W-1:0] in_real,
    input  wire  signed [dde_pkg::SAMPLE_W-1:0] in_imag,
    output logic                               result_strobe,
    output logic signed [dde_pkg::OUT_W-1:0]    out_real,
    output logic signed [dde_pkg::OUT_W-1:0]    out_imag,
    output logic        [dde_pkg::BIN_W-1:0]    bin_index,
    output logic                               last_bin
);

    import dde_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);
    localparam logic [IDX_W:0]   IDX_WRAP = (IDX_W + 1)'(POINTS);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(POINTS) - 64'd1) / POINTS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_EMIT
    } state_t;

    function automatic logic [TW_W-1:0] to_q15(input longint v);
        longint rr;
        rr = (v + 64'sd16384) >>> 15;
        if (v < 0)
        begin
            rr = 0;
        end
        if (rr > 32767)
        begin
            rr = 32767;
        end
        return TW_W'(rr);
    endfunction

    function automatic twiddle_t twiddle_entry(input int m);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        longint sv;
        longint cv;
        logic signed [TW_W-1:0] sq;
        logic signed [TW_W-1:0] cq;
        twiddle_t tw;
        q  = 64'(4 * m) / POINTS;
        r  = 64'(4 * m) % POINTS;
        x  = (r * HALF_PI_Q30) / POINTS;
        x2 = (x * x) >> 30;
        ts = x;
        tc = ONE_Q30;
        sv = longint'(x);
        cv = longint'(ONE_Q30);
        ts = ((ts * x2) >> 30) / 6;
        tc = ((tc * x2) >> 30) / 2;
        sv = sv - longint'(ts);
        cv = cv - longint'(tc);
        ts = ((ts * x2) >> 30) / 20;
        tc = ((tc * x2) >> 30) / 12;
        sv = sv + longint'(ts);
        cv = cv + longint'(tc);
        ts = ((ts * x2) >> 30) / 42;
        tc = ((tc * x2) >> 30) / 30;
        sv = sv - longint'(ts);
        cv = cv - longint'(tc);
        ts = ((ts * x2) >> 30) / 72;
        tc = ((tc * x2) >> 30) / 56;
        sv = sv + longint'(ts);
        cv = cv + longint'(tc);
        ts = ((ts * x2) >> 30) / 110;
        tc = ((tc * x2) >> 30) / 90;
        sv = sv - longint'(ts);
        cv = cv - longint'(tc);
        ts = ((ts * x2) >> 30) / 156;
        tc = ((tc * x2) >> 30) / 132;
        sv = sv + longint'(ts);
        cv = cv + longint'(tc);
        ts = ((ts * x2) >> 30) / 210;
        tc = ((tc * x2) >> 30) / 182;
        sv = sv - longint'(ts);
        cv = cv - longint'(tc);
        sq = to_q15(sv);
        cq = to_q15(cv);
        case (q[1:0])
            2'd0:
            begin
                tw.cos_v = cq;
                tw.sin_v = sq;
            end
            2'd1:
            begin
                tw.cos_v = -sq;
                tw.sin_v = cq;
            end
            2'd2:
            begin
                tw.cos_v = -cq;
                tw.sin_v = -sq;
            end
            default:
            begin
                tw.cos_v = sq;
                tw.sin_v = -cq;
            end
        endcase
        return tw;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[OUT_W-1:0];
    endfunction

    twiddle_t tw_rom [POINTS];

    for (genvar g = 0; g < POINTS; g++)
    begin : g_rom
        assign tw_rom[g] = twiddle_entry(g);
    end

    sample_t sample_mem [POINTS];

    state_t                      state_reg;
    logic                        inverse_reg;
    logic                        frame_inv_reg;
    logic [IDX_W-1:0]            load_cnt_reg;
    logic [IDX_W-1:0]            n_reg;
    logic [IDX_W-1:0]            m_reg;
    logic [IDX_W-1:0]            k_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    sample_t                     rd_reg;
    twiddle_t                    tw_reg;
    logic signed [PROD_W-1:0]    p_rc_reg;
    logic signed [PROD_W-1:0]    p_rs_reg;
    logic signed [PROD_W-1:0]    p_ic_reg;
    logic signed [PROD_W-1:0]    p_is_reg;
    logic signed [ACC_W-1:0]     acc_re_reg;
    logic signed [ACC_W-1:0]     acc_im_reg;
    logic                        neg_re_reg;
    logic                        neg_im_reg;
    logic [ACC_W+RECIP_W-1:0]    prod_re_reg;
    logic [ACC_W+RECIP_W-1:0]    prod_im_reg;
    logic                        strobe_reg;
    logic signed [OUT_W-1:0]     out_re_reg;
    logic signed [OUT_W-1:0]     out_im_reg;
    logic [BIN_W-1:0]            bin_reg;
    logic                        last_reg;

    logic                        accept;
    logic [IDX_W:0]              m_sum;
    logic [IDX_W-1:0]            m_next;
    logic signed [PROD_W-SAMPLE_W:0] t_rc;
    logic signed [PROD_W-SAMPLE_W:0] t_rs;
    logic signed [PROD_W-SAMPLE_W:0] t_ic;
    logic signed [PROD_W-SAMPLE_W:0] t_is;
    logic signed [ACC_W-1:0]     term_re;
    logic signed [ACC_W-1:0]     term_im;
    logic [ACC_W-1:0]            mag_re;
    logic [ACC_W-1:0]            mag_im;
    logic [ACC_W-1:0]            quo_re;
    logic [ACC_W-1:0]            quo_im;
    logic signed [ACC_W-1:0]     res_re;
    logic signed [ACC_W-1:0]     res_im;

    assign accept = start && (state_reg == ST_LOAD);

    assign m_sum  = {1'b0, m_reg} + {1'b0, k_reg};
    assign m_next = (m_sum >= IDX_WRAP) ? IDX_W'(m_sum - IDX_WRAP) : m_sum[IDX_W-1:0];

    assign t_rc = p_rc_reg[PROD_W-1:SAMPLE_W-1];
    assign t_rs = p_rs_reg[PROD_W-1:SAMPLE_W-1];
    assign t_ic = p_ic_reg[PROD_W-1:SAMPLE_W-1];
    assign t_is = p_is_reg[PROD_W-1:SAMPLE_W-1];

    always_comb
    begin
        if (frame_inv_reg)
        begin
            term_re = ACC_W'(t_rc) - ACC_W'(t_is);
            term_im = ACC_W'(t_rs) + ACC_W'(t_ic);
        end
        else
        begin
            term_re = ACC_W'(t_rc) + ACC_W'(t_is);
            term_im = ACC_W'(t_ic) - ACC_W'(t_rs);
        end
    end

    assign mag_re = acc_re_reg[ACC_W-1] ? ACC_W'(-acc_re_reg) : ACC_W'(acc_re_reg);
    assign mag_im = acc_im_reg[ACC_W-1] ? ACC_W'(-acc_im_reg) : ACC_W'(acc_im_reg);
    assign quo_re = prod_re_reg[ACC_W+RECIP_W-1:DIV_SHIFT];
    assign quo_im = prod_im_reg[ACC_W+RECIP_W-1:DIV_SHIFT];

    always_comb
    begin
        if (frame_inv_reg)
        begin
            res_re = neg_re_reg ? -$signed(quo_re) : $signed(quo_re);
            res_im = neg_im_reg ? -$signed(quo_im) : $signed(quo_im);
        end
        else
        begin
            res_re = acc_re_reg;
            res_im = acc_im_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_mem[load_cnt_reg] <= '{imag: in_imag, real_part: in_real};
        end
        if (state_reg == ST_MAC)
        begin
            rd_reg <= sample_mem[n_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            inverse_reg   <= 1'b0;
            frame_inv_reg <= 1'b0;
            load_cnt_reg  <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            k_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            tw_reg        <= '0;
            p_rc_reg      <= '0;
            p_rs_reg      <= '0;
            p_ic_reg      <= '0;
            p_is_reg      <= '0;
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            neg_re_reg    <= 1'b0;
            neg_im_reg    <= 1'b0;
            prod_re_reg   <= '0;
            prod_im_reg   <= '0;
            strobe_reg    <= 1'b0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
            bin_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            v1_reg     <= (state_reg == ST_MAC);
            v2_reg     <= v1_reg;

            if (cfg_write_en)
            begin
                inverse_reg <= cfg_write_data;
            end

            if (state_reg == ST_MAC)
            begin
                tw_reg <= tw_rom[m_reg];
            end

            if (v1_reg)
            begin
                p_rc_reg <= rd_reg.real_part * tw_reg.cos_v;
                p_rs_reg <= rd_reg.real_part * tw_reg.sin_v;
                p_ic_reg <= rd_reg.imag * tw_reg.cos_v;
                p_is_reg <= rd_reg.imag * tw_reg.sin_v;
            end

            if (v2_reg)
            begin
                acc_re_reg <= acc_re_reg + term_re;
                acc_im_reg <= acc_im_reg + term_im;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (load_cnt_reg == IDX_LAST)
                        begin
                            load_cnt_reg  <= '0;
                            frame_inv_reg <= inverse_reg;
                            k_reg         <= '0;
                            n_reg         <= '0;
                            m_reg         <= '0;
                            acc_re_reg    <= '0;
                            acc_im_reg    <= '0;
                            state_reg     <= ST_MAC;
                        end
                        else
                        begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_MAC:
                begin
                    n_reg <= n_reg + 1'b1;
                    m_reg <= m_next;
                    if (n_reg == IDX_LAST)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    neg_re_reg  <= acc_re_reg[ACC_W-1];
                    neg_im_reg  <= acc_im_reg[ACC_W-1];
                    prod_re_reg <= mag_re * RECIP;
                    prod_im_reg <= mag_im * RECIP;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    out_re_reg <= sat_out(res_re);
                    out_im_reg <= sat_out(res_im);
                    bin_reg    <= BIN_W'(k_reg);
                    last_reg   <= (k_reg == IDX_LAST);
                    n_reg      <= '0;
                    m_reg      <= '0;
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                    if (k_reg == IDX_LAST)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_LOAD);
    assign result_strobe = strobe_reg;
    assign out_real      = out_re_reg;
    assign out_imag      = out_im_reg;
    assign bin_index     = bin_reg;
    assign last_bin      = last_reg;

endmodule

`default_nettype wire
